// ===== hw/rtl/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the weighted face sampler.
// ----------------------------------------------------------------------------
package wfs_pkg;

  localparam int VAL_W  = 8;
  localparam int WGT_W  = 8;
  localparam int RND_W  = 32;
  localparam int IN_IDX_W = 4;
  localparam int CFG_W  = 5;
  localparam int ACT_RESET = 6;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_WEIGHT = 2'd1,
    MODE_ROLL   = 2'd2,
    MODE_FILL   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              val_en;
    logic              wgt_en;
    logic              fill_en;
    logic [VAL_W-1:0]  value;
    logic [WGT_W-1:0]  weight;
  } tbl_wr_t;

endpackage

// ===== hw/rtl/wfs_alu.sv =====
// ----------------------------------------------------------------------------
// wfs_alu
// Shared add/subtract unit; borrow flags a < b on subtract.
// ----------------------------------------------------------------------------
module wfs_alu #(
  parameter int W = 15
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         borrow
);

  logic [W:0] sum;

  assign sum    = {1'b0, a} + {1'b0, (b ^ {W{sub}})} + (W+1)'(sub);
  assign res    = sum[W-1:0];
  assign borrow = sub & ~sum[W];

endmodule

// ===== hw/rtl/wfs_table.sv =====
// ----------------------------------------------------------------------------
// wfs_table
// Face value and weight storage, one access per cycle, registered read.
// Entries without a valid bit read as their reset contents.
// ----------------------------------------------------------------------------
module wfs_table
  import wfs_pkg::*;
#(
  parameter int MAX_FACES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tbl_wr_t                              wr,
  input  logic [$clog2(MAX_FACES)-1:0]         addr,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_FACES+1)-1:0]       act,
  output logic [VAL_W-1:0]                     rd_val,
  output logic [WGT_W-1:0]                     rd_wgt
);

  localparam int IDX_W = $clog2(MAX_FACES);

  logic [VAL_W-1:0]     val_mem [MAX_FACES];
  logic [WGT_W-1:0]     wgt_mem [MAX_FACES];
  logic [MAX_FACES-1:0] val_vld_r;
  logic [MAX_FACES-1:0] wgt_vld_r;
  logic [VAL_W-1:0]     rd_val_r;
  logic [WGT_W-1:0]     rd_wgt_r;
  logic                 rd_val_vld_r;
  logic                 rd_wgt_vld_r;
  logic [IDX_W-1:0]     rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr.val_en) begin
      val_mem[addr] <= wr.value;
    end
    if (wr.wgt_en) begin
      wgt_mem[addr] <= wr.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val_r     <= val_mem[addr];
      rd_wgt_r     <= wgt_mem[addr];
      rd_val_vld_r <= val_vld_r[addr];
      rd_wgt_vld_r <= wgt_vld_r[addr];
      rd_addr_r    <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_vld_r <= '0;
      wgt_vld_r <= '0;
    end else begin
      if (wr.fill_en) begin
        for (int i = 0; i < MAX_FACES; i++) begin
          if (32'(i) < 32'(act)) begin
            val_vld_r[i] <= 1'b0;
            wgt_vld_r[i] <= 1'b0;
          end
        end
      end
      if (wr.val_en) begin
        val_vld_r[addr] <= 1'b1;
      end
      if (wr.wgt_en) begin
        wgt_vld_r[addr] <= 1'b1;
      end
    end
  end

  assign rd_val = rd_val_vld_r ? rd_val_r : (VAL_W'(rd_addr_r) + VAL_W'(1));
  assign rd_wgt = rd_wgt_vld_r ? rd_wgt_r : WGT_W'(1);

endmodule

// ===== hw/rtl/wfs_seq.sv =====
// ----------------------------------------------------------------------------
// wfs_seq
// Command decode and roll sequencer: weight sum, bit-serial modulo and
// running-sum walk, all on one shared adder.
// ----------------------------------------------------------------------------
module wfs_seq
  import wfs_pkg::*;
#(
  parameter int MAX_FACES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_mode,
  input  logic [IN_IDX_W-1:0]                  in_entry_index,
  input  logic [VAL_W-1:0]                     in_face_value,
  input  logic [WGT_W-1:0]                     in_weight,
  input  logic [RND_W-1:0]                     in_random_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [VAL_W-1:0]                     out_chosen_face,
  input  logic [$clog2(MAX_FACES+1)-1:0]       act,
  output tbl_wr_t                              tbl_wr,
  output logic [$clog2(MAX_FACES)-1:0]         tbl_addr,
  output logic                                 tbl_rd_en,
  input  logic [VAL_W-1:0]                     tbl_val,
  input  logic [WGT_W-1:0]                     tbl_wgt
);

  localparam int IDX_W   = $clog2(MAX_FACES);
  localparam int CNT_W   = $clog2(MAX_FACES+1);
  localparam int TOT_W   = $clog2(MAX_FACES*255+1);
  localparam int ALU_W   = TOT_W + 1;
  localparam int DCNT_W  = $clog2(RND_W);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    widx_r;
  logic                pend_r;
  logic                zero_r;
  logic [TOT_W-1:0]    total_r;
  logic [TOT_W-1:0]    rem_r;
  logic [RND_W-1:0]    rnd_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic [VAL_W-1:0]    chosen_r;
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_face_r;

  logic                accept;
  logic                idx_ok;
  logic                rd_en;
  logic                hit;
  logic                sum_done;
  logic                div_done;
  logic                out_load;
  logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_sub, alu_borrow;

  wfs_alu #(.W(ALU_W)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  assign accept = in_valid && (state_r == ST_IDLE);
  assign idx_ok = 32'(in_entry_index) < 32'(act);

  // control and datapath selects
  always_comb begin
    rd_en    = 1'b0;
    alu_sub  = 1'b0;
    alu_a    = {1'b0, total_r};
    alu_b    = ALU_W'(tbl_wgt);
    hit      = 1'b0;
    sum_done = 1'b0;
    div_done = 1'b0;
    out_load = 1'b0;
    tbl_wr   = '0;
    tbl_wr.value  = in_face_value;
    tbl_wr.weight = in_weight;
    tbl_addr = IDX_W'(32'(in_entry_index));
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_WRITE: begin
              tbl_wr.val_en = idx_ok;
              tbl_wr.wgt_en = idx_ok;
            end
            MODE_WEIGHT: tbl_wr.wgt_en = idx_ok;
            MODE_FILL:   tbl_wr.fill_en = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        rd_en    = cnt_r < act;
        tbl_addr = cnt_r[IDX_W-1:0];
        sum_done = !rd_en && !pend_r;
      end
      ST_DIV: begin
        alu_sub  = 1'b1;
        alu_a    = {rem_r, rnd_r[RND_W-1]};
        alu_b    = {1'b0, total_r};
        div_done = dcnt_r == DCNT_W'(RND_W-1);
      end
      ST_WALK: begin
        rd_en    = cnt_r < act;
        tbl_addr = cnt_r[IDX_W-1:0];
        alu_sub  = 1'b1;
        alu_a    = {1'b0, rem_r};
        hit      = pend_r && (zero_r || alu_borrow || (widx_r == act - CNT_W'(1)));
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && (in_mode == MODE_ROLL)) state_nxt = ST_SUM;
      ST_SUM: begin
        if (sum_done) begin
          state_nxt = (total_r == '0) ? ST_WALK : ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_WALK;
      ST_WALK: if (hit) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SUM:  pend_r <= sum_done ? 1'b0 : rd_en;
        ST_WALK: pend_r <= rd_en;
        default: pend_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        total_r <= '0;
        rem_r   <= '0;
        cnt_r   <= '0;
        widx_r  <= '0;
        dcnt_r  <= '0;
        rnd_r   <= in_random_word;
      end
      ST_SUM: begin
        if (rd_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (pend_r) begin
          total_r <= alu_res[TOT_W-1:0];
        end
        if (sum_done) begin
          cnt_r  <= '0;
          zero_r <= total_r == '0;
        end
      end
      ST_DIV: begin
        rem_r  <= alu_borrow ? alu_a[TOT_W-1:0] : alu_res[TOT_W-1:0];
        rnd_r  <= {rnd_r[RND_W-2:0], 1'b0};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      ST_WALK: begin
        if (rd_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (hit) begin
            chosen_r <= tbl_val;
          end else begin
            rem_r  <= alu_res[TOT_W-1:0];
            widx_r <= widx_r + CNT_W'(1);
          end
        end
      end
      ST_DONE: if (out_load) out_face_r <= chosen_r;
      default: ;
    endcase
  end

  assign tbl_rd_en       = rd_en;
  assign in_stall        = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_chosen_face = out_face_r;

endmodule

// ===== hw/rtl/weighted_face_sampler_top.sv =====
// ----------------------------------------------------------------------------
// weighted_face_sampler_top
// Weighted random face selection over a table of up to MAX_FACES faces.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    mode, entry_index, face_value,
//                                        weight, random_word
//   out_     output     valid / stall    chosen_face (rolls only)
//   cfg_     input      valid / ready    active_faces
//
// Write, set weight and uniform fill are applied in the idle state and leave it idle.
// A roll makes one table read per cycle for the weight sum and the walk,
// and runs a 32-step restoring modulo on the shared adder; a zero total
// skips the modulo.
// Reset is synchronous; the table reads as its reset contents at once.
// A held result blocks the next roll only at its final step.
// ----------------------------------------------------------------------------
module weighted_face_sampler_top
  import wfs_pkg::*;
#(
  parameter int MAX_FACES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [IN_IDX_W-1:0]  in_entry_index,
  input  logic [VAL_W-1:0]     in_face_value,
  input  logic [WGT_W-1:0]     in_weight,
  input  logic [RND_W-1:0]     in_random_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_chosen_face,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_active_faces
);

  localparam int IDX_W   = $clog2(MAX_FACES);
  localparam int CNT_W   = $clog2(MAX_FACES+1);
  localparam int ACT_RST = (MAX_FACES < ACT_RESET) ? MAX_FACES : ACT_RESET;

  logic [CNT_W-1:0] act_r, act_nxt;
  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] tbl_addr;
  logic             tbl_rd_en;
  logic [VAL_W-1:0] tbl_val;
  logic [WGT_W-1:0] tbl_wgt;

  always_comb begin
    if (cfg_active_faces == '0) begin
      act_nxt = CNT_W'(1);
    end else if (32'(cfg_active_faces) > 32'(MAX_FACES)) begin
      act_nxt = CNT_W'(MAX_FACES);
    end else begin
      act_nxt = CNT_W'(32'(cfg_active_faces));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= CNT_W'(ACT_RST);
    end else if (cfg_valid && cfg_ready) begin
      act_r <= act_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  wfs_table #(.MAX_FACES(MAX_FACES)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .addr   (tbl_addr),
    .rd_en  (tbl_rd_en),
    .act    (act_r),
    .rd_val (tbl_val),
    .rd_wgt (tbl_wgt)
  );

  wfs_seq #(.MAX_FACES(MAX_FACES)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_face_value   (in_face_value),
    .in_weight       (in_weight),
    .in_random_word  (in_random_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chosen_face (out_chosen_face),
    .act             (act_r),
    .tbl_wr          (tbl_wr),
    .tbl_addr        (tbl_addr),
    .tbl_rd_en       (tbl_rd_en),
    .tbl_val         (tbl_val),
    .tbl_wgt         (tbl_wgt)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_face_sampler_top. A directed table covers
// reset contents, extreme fields, ignored writes, zero total weight and
// uniform fill. Random phases follow, one per face count. Every transfer on
// the input channel runs through a local copy of the face table. Each roll
// queues the face it should return, and the output monitor compares each
// transfer against the oldest queued face. Both channels idle at random, and
// one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfs_pkg::*;

  localparam int FACE_SLOTS     = 16;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 60;
  localparam int PHASES         = 8;
  localparam int DIRECTED_ROWS  = 24;

  typedef struct {
    mode_t                mode;
    logic [IN_IDX_W-1:0]  entry;
    logic [VAL_W-1:0]     value;
    logic [WGT_W-1:0]     weight;
    logic [RND_W-1:0]     word;
    bit                   typed;
    logic [VAL_W-1:0]     face;
  } face_cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_mode;
  logic [IN_IDX_W-1:0]  in_entry_index;
  logic [VAL_W-1:0]     in_face_value;
  logic [WGT_W-1:0]     in_weight;
  logic [RND_W-1:0]     in_random_word;
  logic                 out_valid;
  logic                 out_stall;
  logic [VAL_W-1:0]     out_chosen_face;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_active_faces;

  logic [VAL_W-1:0]  face_value_tbl [FACE_SLOTS];
  logic [WGT_W-1:0]  face_weight_tbl [FACE_SLOTS];
  int unsigned       active_cnt;
  logic [VAL_W-1:0]  pending_faces [$];
  int                mismatch_count = 0;
  bit                idle_on = 1'b1;
  bit                rx_hold_req = 1'b0;

  logic [CFG_W-1:0] phase_counts [PHASES] =
    '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd9, 5'd12};

  face_cmd_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'd0,         1'b1, 8'd1},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'd5,         1'b1, 8'd6},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 8'd4},
    '{MODE_WRITE,  4'd0,  8'hFF, 8'hFF, 32'd0,         1'b0, 8'd0},
    '{MODE_WRITE,  4'd15, 8'hAA, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'd0,         1'b1, 8'hFF},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd5,  8'h00, 8'h80, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'h8000_0000, 1'b0, 8'd0},
    '{MODE_WRITE,  4'd6,  8'h55, 8'h09, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd15, 8'h00, 8'hFF, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd0,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd1,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd2,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd3,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd4,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_WEIGHT, 4'd5,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'h1234_5678, 1'b1, 8'hFF},
    '{MODE_WRITE,  4'd5,  8'h00, 8'h01, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, 8'd0},
    '{MODE_FILL,   4'd0,  8'h00, 8'h00, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'd2,         1'b1, 8'd3},
    '{MODE_WRITE,  4'd3,  8'h5A, 8'hA5, 32'd0,         1'b0, 8'd0},
    '{MODE_ROLL,   4'd0,  8'h00, 8'h00, 32'd7,         1'b0, 8'd0}
  };

  weighted_face_sampler_top #(.MAX_FACES(FACE_SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_face_value    (in_face_value),
    .in_weight        (in_weight),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_face  (out_chosen_face),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_faces (cfg_active_faces)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_face_table();
    for (int i = 0; i < FACE_SLOTS; i++) begin
      face_value_tbl[i]  = VAL_W'(i + 1);
      face_weight_tbl[i] = WGT_W'(1);
    end
    active_cnt = ACT_RESET;
  endfunction

  function automatic void set_active_cnt(logic [CFG_W-1:0] req);
    if (req == '0) begin
      active_cnt = 1;
    end else if (req > FACE_SLOTS) begin
      active_cnt = FACE_SLOTS;
    end else begin
      active_cnt = req;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_face(logic [RND_W-1:0] word);
    logic [31:0] total;
    logic [31:0] acc;
    logic [31:0] target;
    total = '0;
    acc = '0;
    for (int i = 0; i < active_cnt; i++) total += face_weight_tbl[i];
    if (total == '0) return face_value_tbl[0];
    target = word % total;
    for (int i = 0; i < active_cnt; i++) begin
      acc += face_weight_tbl[i];
      if (target < acc) return face_value_tbl[i];
    end
    return face_value_tbl[active_cnt-1];
  endfunction

  // updates the table copy; returns 1 when the command yields a face
  function automatic bit advance_face_table(face_cmd_t c, output logic [VAL_W-1:0] face);
    face = '0;
    case (c.mode)
      MODE_WRITE: begin
        if (c.entry < active_cnt) begin
          face_value_tbl[c.entry]  = c.value;
          face_weight_tbl[c.entry] = c.weight;
        end
      end
      MODE_WEIGHT: begin
        if (c.entry < active_cnt) face_weight_tbl[c.entry] = c.weight;
      end
      MODE_ROLL: begin
        face = pick_face(c.word);
        return 1'b1;
      end
      default: begin
        for (int i = 0; i < active_cnt; i++) begin
          face_value_tbl[i]  = VAL_W'(i + 1);
          face_weight_tbl[i] = WGT_W'(1);
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic face_cmd_t random_cmd();
    face_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) c.mode = MODE_ROLL;
    else if (r < 70) c.mode = MODE_WRITE;
    else if (r < 93) c.mode = MODE_WEIGHT;
    else c.mode = MODE_FILL;
    if ($urandom_range(0, 9) < 7) c.entry = IN_IDX_W'($urandom_range(0, active_cnt - 1));
    else c.entry = IN_IDX_W'($urandom_range(0, FACE_SLOTS - 1));
    c.value = VAL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) c.weight = '0;
    else if (r < 25) c.weight = '1;
    else c.weight = WGT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) c.word = '0;
    else if (r < 20) c.word = '1;
    else if (r < 35) c.word = RND_W'($urandom_range(0, 600));
    else c.word = $urandom;
    c.typed = 1'b0;
    c.face = '0;
    return c;
  endfunction

  function automatic void log_failure(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endfunction

  task automatic send_cmd(input face_cmd_t c);
    int gap;
    logic [VAL_W-1:0] face;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= c.mode;
    in_entry_index <= c.entry;
    in_face_value  <= c.value;
    in_weight      <= c.weight;
    in_random_word <= c.word;
    do @(posedge clk); while (in_stall);
    if (advance_face_table(c, face)) pending_faces.push_back(c.typed ? c.face : face);
  endtask

  task automatic drain_faces();
    do @(posedge clk); while (pending_faces.size() != 0);
  endtask

  task automatic write_active_cnt(input logic [CFG_W-1:0] req);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_active_faces <= req;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_active_cnt(req);
  endtask

  // output side: compare each transfer, then draw the next stall
  initial begin : face_monitor
    int wait_left;
    int hold_left;
    logic [VAL_W-1:0] want;
    wait_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_faces.size() == 0) begin
          log_failure($sformatf("unexpected transfer: face %0d", out_chosen_face));
        end else begin
          want = pending_faces.pop_front();
          if (out_chosen_face !== want)
            log_failure($sformatf("face mismatch: expected %0d got %0d",
                                  want, out_chosen_face));
        end
        wait_left = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (rx_hold_req) begin
        hold_left = HOLD_CYCLES;
        rx_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= MODE_WRITE;
    in_entry_index   <= '0;
    in_face_value    <= '0;
    in_weight        <= '0;
    in_random_word   <= '0;
    cfg_valid        <= 1'b0;
    cfg_active_faces <= '0;
    reset_face_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send_cmd(directed_rows[i]);
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      drain_faces();
      write_active_cnt(phase_counts[p]);
      idle_on = (p != 2 && p != 5);
      if (p == 2) rx_hold_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          drain_faces();
        end
        send_cmd(random_cmd());
      end
    end
    in_valid <= 1'b0;
    drain_faces();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_faces.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
